// File: sv/catrom_pkg.sv
// Shared types and constants for the Catmull-Rom curve tessellator.
// No dependencies; imported by every module of the block.
package catrom_pkg;

   // coordinate and curve parameter widths
   localparam int COORD_W = 16;
   localparam int T_W     = 16;
   localparam int T_ONE   = 65536;

   // widths of the doubled cubic coefficients
   localparam int A_W = 17;
   localparam int B_W = 17;
   localparam int C_W = 20;
   localparam int D_W = 19;

   // default number of curve points per segment
   localparam int STEPS_DEFAULT = 50;

   // segment queue depth (power of two)
   localparam int QUEUE_DEPTH = 2;

   // evaluation pipeline length, issue to output register
   localparam int PIPE_L = 8;

   // one coordinate's coefficients: 2*p1, p2-p0, and the t^2 / t^3 terms
   typedef struct packed {
      logic signed [A_W-1:0] a;
      logic signed [B_W-1:0] b;
      logic signed [C_W-1:0] c;
      logic signed [D_W-1:0] d;
   } coef_type;

   // one queued segment
   typedef struct packed {
      coef_type y;
      coef_type x;
   } seg_type;

endpackage

// File: sv/catmull_rom_curve_tessellator_top.sv
// Top level of the uniform Catmull-Rom curve tessellator.
// Depends on catrom_pkg, catrom_front, catrom_queue and catrom_back.
//
// Usage:
//  - req_* takes control points: tdata = {y, x} (Q4.12 each), tuser = restart.
//    The first point after reset or after a restart, and the two after it,
//    only fill the window; every further point closes one segment.
//  - rsp_* returns STEPS curve points per segment, tdata = {y, x} in Q4.12,
//    rounded and saturated; tlast marks the last point of a segment.
//  - Path: with the evaluator idle, a closing point is written into the queue,
//    whose head goes straight to the evaluator; rsp_tvalid rises once the
//    first curve point leaves the 8-stage multiply pipeline.
//  - Throughput: one curve point per cycle while rsp_tready allows; a
//    closed segment occupies the evaluator for its STEPS points, and the
//    two-entry queue keeps the segment in evaluation until its last
//    point issues; one more closed segment can wait, then req_tready drops.
//  - When rsp_tready is low with a curve point on the output, the whole
//    evaluation pipeline holds; the front end keeps taking points until the queue is full.
//  - Reset clears the window, the queue and the pipeline; it needs no
//    clearing pass.
module catmull_rom_curve_tessellator_top #(
   parameter int STEPS = catrom_pkg::STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] curve_x, [31:16] curve_y
   output logic        rsp_tlast    // segment_end
);
   import catrom_pkg::*;

   seg_type                   push_data;
   seg_type                   head;
   logic                      seg_push;
   logic                      seg_pop;
   logic                      seg_full;
   logic                      seg_valid;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;

   catrom_front u_front (
      .clock      (clock),
      .reset      (reset),
      .pt_valid   (req_tvalid),
      .pt_ready   (req_tready),
      .pt_x       ($signed(req_tdata[15:0])),
      .pt_y       ($signed(req_tdata[31:16])),
      .pt_restart (req_tuser[0]),
      .seg_full   (seg_full),
      .seg_push   (seg_push),
      .seg_data   (push_data)
   );

   catrom_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (seg_push),
      .push_data  (push_data),
      .full       (seg_full),
      .pop        (seg_pop),
      .head_valid (seg_valid),
      .head       (head)
   );

   catrom_back #(
      .STEPS (STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (seg_valid),
      .seg       (head),
      .seg_pop   (seg_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {out_y, out_x};

   // the evaluator never retires a segment that is not queued
   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      seg_pop |-> seg_valid)
      else $error("segment popped from empty queue");

   // the front end never pushes into a full queue
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      seg_push |-> !seg_full)
      else $error("segment pushed into full queue");

   // reset empties the result pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// File: sv/catrom_front.sv
// Front end: point window, restart handling and segment coefficient setup.
// Depends on catrom_pkg; feeds catrom_queue.
module catrom_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pt_valid,
   output logic                                  pt_ready,
   input  logic signed [catrom_pkg::COORD_W-1:0] pt_x,
   input  logic signed [catrom_pkg::COORD_W-1:0] pt_y,
   input  logic                                  pt_restart,
   input  logic                                  seg_full,
   output logic                                  seg_push,
   output catrom_pkg::seg_type                   seg_data
);
   import catrom_pkg::*;

   localparam int CALC_W = 22;

   logic signed [COORD_W-1:0] wx_ff [3];
   logic signed [COORD_W-1:0] wy_ff [3];
   logic signed [COORD_W-1:0] wx_in [3];
   logic signed [COORD_W-1:0] wy_in [3];
   logic [1:0]                held_ff;
   logic [1:0]                held_in;
   logic                      accept;

   // doubled coefficients of the uniform Catmull-Rom cubic
   function automatic coef_type make_coef(input logic signed [COORD_W-1:0] p0,
                                          input logic signed [COORD_W-1:0] p1,
                                          input logic signed [COORD_W-1:0] p2,
                                          input logic signed [COORD_W-1:0] p3);
      logic signed [CALC_W-1:0] e0, e1, e2, e3;
      coef_type r;
      e0 = CALC_W'(p0);
      e1 = CALC_W'(p1);
      e2 = CALC_W'(p2);
      e3 = CALC_W'(p3);
      r.a = A_W'(e1 <<< 1);
      r.b = B_W'(e2 - e0);
      r.c = C_W'((e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3);
      r.d = D_W'(((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) - e0 + e3);
      return r;
   endfunction

   assign pt_ready = !seg_full;
   assign accept   = pt_valid && pt_ready;

   // a full window plus the new point closes a segment
   assign seg_push   = accept && !pt_restart && (held_ff == 2'd3);
   assign seg_data.x = make_coef(wx_ff[0], wx_ff[1], wx_ff[2], pt_x);
   assign seg_data.y = make_coef(wy_ff[0], wy_ff[1], wy_ff[2], pt_y);

   // window update
   always_comb begin
      wx_in   = wx_ff;
      wy_in   = wy_ff;
      held_in = held_ff;
      if (accept) begin
         if (pt_restart) begin
            wx_in[0] = '0;
            wx_in[1] = '0;
            wy_in[0] = '0;
            wy_in[1] = '0;
            held_in  = 2'd1;
         end else begin
            wx_in[0] = wx_ff[1];
            wx_in[1] = wx_ff[2];
            wy_in[0] = wy_ff[1];
            wy_in[1] = wy_ff[2];
            if (held_ff != 2'd3) begin
               held_in = held_ff + 2'd1;
            end
         end
         wx_in[2] = pt_x;
         wy_in[2] = pt_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wx_ff   <= '{default: '0};
         wy_ff   <= '{default: '0};
         held_ff <= '0;
      end else begin
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         held_ff <= held_in;
      end
   end

endmodule

// File: sv/catrom_queue.sv
// Short segment queue between front end and evaluator.
// Depends on catrom_pkg.
module catrom_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  catrom_pkg::seg_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output catrom_pkg::seg_type head
);
   import catrom_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   seg_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/catrom_lane.sv
// One coordinate of the cubic evaluator: an eight-stage multiply pipeline.
// Depends on catrom_pkg; instantiated twice by catrom_back.
module catrom_lane (
   input  logic                                  clock,
   input  logic                                  adv,
   input  catrom_pkg::coef_type                  coef,
   input  logic [catrom_pkg::T_W-1:0]            t,
   output logic signed [catrom_pkg::COORD_W-1:0] value
);
   import catrom_pkg::*;

   localparam int TS_W = T_W + 1;
   localparam int M1_W = D_W + TS_W;
   localparam int U_W  = M1_W + 1;
   localparam int PH_W = (U_W - 16) + TS_W;
   localparam int PL_W = 2 * T_W;
   localparam int S_W  = 55;
   localparam int R_W  = S_W - 16;
   localparam int QH_W = (R_W - 16) + TS_W;
   localparam int F_W  = 57;
   localparam int V_W  = F_W - 33;
   localparam logic signed [V_W-1:0] V_MAX = V_W'(32767);
   localparam logic signed [V_W-1:0] V_MIN = -V_W'(32768);

   // stage 1: d*t
   logic signed [M1_W-1:0] m1_ff;
   logic signed [C_W-1:0]  c1_ff;
   logic signed [B_W-1:0]  b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [A_W-1:0]  a1_ff, a2_ff, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff;
   logic [T_W-1:0]         t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   // stage 2 .. 8
   logic signed [U_W-1:0]  u_ff;
   logic signed [PH_W-1:0] ph_ff, ph4_ff;
   logic [15:0]            ul_ff;
   logic [PL_W-1:0]        pl_ff;
   logic signed [R_W-1:0]  r_ff;
   logic signed [QH_W-1:0] qh_ff, qh7_ff;
   logic [15:0]            rl_ff;
   logic [PL_W-1:0]        ql_ff;
   logic signed [COORD_W-1:0] value_ff;

   logic signed [M1_W-1:0] m1_in;
   logic signed [U_W-1:0]  u_in;
   logic signed [PH_W-1:0] ph_in;
   logic [PL_W-1:0]        pl_in;
   logic signed [S_W-1:0]  s_sum;
   logic signed [R_W-1:0]  r_in;
   logic signed [QH_W-1:0] qh_in;
   logic [PL_W-1:0]        ql_in;
   logic signed [F_W-1:0]  f_sum;
   logic signed [V_W-1:0]  v_full;
   logic signed [COORD_W-1:0] value_in;

   // datapath between stages
   always_comb begin
      m1_in = coef.d * $signed({1'b0, t});
      u_in  = U_W'(m1_ff) + (U_W'(c1_ff) <<< 16);
      ph_in = $signed(u_ff[U_W-1:16]) * $signed({1'b0, t2_ff});
      pl_in = ul_ff * t3_ff;
      s_sum = (S_W'(ph4_ff) <<< 16) + S_W'($signed({1'b0, pl_ff}))
            + (S_W'(b4_ff) <<< 32) + S_W'(32768);
      r_in  = R_W'(s_sum >>> 16);
      qh_in = $signed(r_ff[R_W-1:16]) * $signed({1'b0, t5_ff});
      ql_in = rl_ff * t6_ff;
      f_sum = (F_W'(qh7_ff) <<< 16) + F_W'($signed({1'b0, ql_ff}))
            + (F_W'(a7_ff) <<< 32) + (F_W'(1) <<< 32);
      v_full = V_W'(f_sum >>> 33);
      if (v_full > V_MAX) begin
         value_in = COORD_W'(V_MAX);
      end else if (v_full < V_MIN) begin
         value_in = COORD_W'(V_MIN);
      end else begin
         value_in = COORD_W'(v_full);
      end
   end

   // pipeline registers, all moving together
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= m1_in;
         c1_ff    <= coef.c;
         b1_ff    <= coef.b;
         a1_ff    <= coef.a;
         t1_ff    <= t;
         u_ff     <= u_in;
         b2_ff    <= b1_ff;
         a2_ff    <= a1_ff;
         t2_ff    <= t1_ff;
         ph_ff    <= ph_in;
         ul_ff    <= u_ff[15:0];
         b3_ff    <= b2_ff;
         a3_ff    <= a2_ff;
         t3_ff    <= t2_ff;
         pl_ff    <= pl_in;
         ph4_ff   <= ph_ff;
         b4_ff    <= b3_ff;
         a4_ff    <= a3_ff;
         t4_ff    <= t3_ff;
         r_ff     <= r_in;
         a5_ff    <= a4_ff;
         t5_ff    <= t4_ff;
         qh_ff    <= qh_in;
         rl_ff    <= r_ff[15:0];
         a6_ff    <= a5_ff;
         t6_ff    <= t5_ff;
         ql_ff    <= ql_in;
         qh7_ff   <= qh_ff;
         a7_ff    <= a6_ff;
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: sv/catrom_back.sv
// Back end: steps t across a queued segment and runs both coordinate lanes.
// Depends on catrom_pkg and catrom_lane.
module catrom_back #(
   parameter int STEPS = catrom_pkg::STEPS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  seg_valid,
   input  catrom_pkg::seg_type                   seg,
   output logic                                  seg_pop,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [catrom_pkg::COORD_W-1:0] out_x,
   output logic signed [catrom_pkg::COORD_W-1:0] out_y,
   output logic                                  out_last
);
   import catrom_pkg::*;

   localparam int K_W    = $clog2(STEPS);
   localparam int REM_W  = $clog2(STEPS) + 1;
   localparam int STEP_Q = T_ONE / STEPS;
   localparam int STEP_R = T_ONE % STEPS;
   localparam int REM_0  = STEPS / 2;

   logic [K_W-1:0]    k_ff, k_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  rem_sum;
   logic [PIPE_L-1:0] vld_ff, vld_in;
   logic [PIPE_L-1:0] last_ff;
   logic              adv;
   logic              issue;
   logic              is_last;

   // whole pipeline moves when the output register is free or drained
   assign adv     = !vld_ff[PIPE_L-1] || out_ready;
   assign issue   = adv && seg_valid;
   assign is_last = (k_ff == K_W'(STEPS - 1));
   assign seg_pop = issue && is_last;

   // t = k / STEPS in Q0.16 rounded to nearest, kept as quotient and remainder
   always_comb begin
      k_in    = k_ff;
      t_in    = t_ff;
      rem_in  = rem_ff;
      rem_sum = rem_ff + REM_W'(STEP_R);
      if (issue) begin
         if (is_last) begin
            k_in   = '0;
            t_in   = '0;
            rem_in = REM_W'(REM_0);
         end else begin
            k_in = k_ff + K_W'(1);
            if (rem_sum >= REM_W'(STEPS)) begin
               rem_in = rem_sum - REM_W'(STEPS);
               t_in   = t_ff + T_W'(STEP_Q) + T_W'(1);
            end else begin
               rem_in = rem_sum;
               t_in   = t_ff + T_W'(STEP_Q);
            end
         end
      end
      vld_in = adv ? {vld_ff[PIPE_L-2:0], issue} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         t_ff   <= '0;
         rem_ff <= REM_W'(REM_0);
         vld_ff <= '0;
      end else begin
         k_ff   <= k_in;
         t_ff   <= t_in;
         rem_ff <= rem_in;
         vld_ff <= vld_in;
      end
   end

   // segment end marker travels beside the data
   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= {last_ff[PIPE_L-2:0], is_last};
      end
   end

   catrom_lane u_lane_x (
      .clock (clock),
      .adv   (adv),
      .coef  (seg.x),
      .t     (t_ff),
      .value (out_x)
   );

   catrom_lane u_lane_y (
      .clock (clock),
      .adv   (adv),
      .coef  (seg.y),
      .t     (t_ff),
      .value (out_y)
   );

   assign out_valid = vld_ff[PIPE_L-1];
   assign out_last  = last_ff[PIPE_L-1];

endmodule
